/* hw/rtl/sha512_pkg.sv */
// SHA-512 compression package: sequencer state type, round constants,
// initial hash values and the round/schedule functions.
// No dependencies; imported by sha512_compression_unit.
package sha512_pkg;

    localparam int ROUNDS      = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int WORD_W      = 64;
    localparam int HASH_WORDS  = 8;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int SLOT_W      = $clog2(BLOCK_WORDS);
    localparam int HIDX_W      = $clog2(HASH_WORDS);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_SIG,
        ST_RD_W,
        ST_WORD,
        ST_T1,
        ST_UPD,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam word_t RC [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam word_t IV [HASH_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

/* hw/rtl/sha512_compression_unit.sv */
// SHA-512 compression unit: message word loading, round sequencer over a
// 16-entry schedule memory, hash update and digest output.
// Depends on sha512_pkg.

// Accepts 64-bit padded message words, sixteen per 1024-bit block, one per
// cycle while loading. After the sixteenth word the unit stops taking words
// and runs 80 rounds, each a sequence of two registered reads of the schedule
// memory, schedule word update, T1 sum and working variable update, then
// adds into the hash words. s_tready stays low throughout. If the block's last
// word carried tlast, the eight digest words follow on the m_ side, H0 first,
// tlast on H7, with s_tready still low, and the hash words return to the
// initial values afterwards.
module sha512_compression_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // message_word[63:0]
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic        m_tlast    // digest_last
);
    import sha512_pkg::*;

    state_t state_reg, state_next;

    word_t sched_mem [BLOCK_WORDS];

    logic [ROUND_W-1:0] round_reg;
    logic [SLOT_W-1:0]  word_cnt_reg;
    logic [HIDX_W-1:0]  out_idx_reg;
    logic               end_reg;

    word_t hash_reg [HASH_WORDS];
    word_t var_reg  [HASH_WORDS];
    word_t rd_a_reg, rd_b_reg;
    word_t sig_reg, w_reg, hk_reg, t1_reg;

    logic [SLOT_W-1:0] slot, addr_a, addr_b, wr_addr;
    logic              wr_en;
    word_t             wr_data, w_new;
    logic              s_acc, m_acc, block_done, last_round;

    assign s_acc      = s_tvalid && s_tready;
    assign m_acc      = m_tvalid && m_tready;
    assign block_done = s_acc && (word_cnt_reg == SLOT_W'(BLOCK_WORDS - 1));
    assign last_round = (round_reg == ROUND_W'(ROUNDS - 1));
    assign slot       = round_reg[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (block_done) begin
                    state_next = ST_RD_SIG;
                end
            end
            ST_RD_SIG: state_next = ST_RD_W;
            ST_RD_W:   state_next = ST_WORD;
            ST_WORD:   state_next = ST_T1;
            ST_T1:     state_next = ST_UPD;
            ST_UPD:    state_next = last_round ? ST_ADD : ST_RD_SIG;
            ST_ADD:    state_next = end_reg ? ST_OUT : ST_LOAD;
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_acc && (out_idx_reg == HIDX_W'(HASH_WORDS - 1))) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // first read pair: W[r-15], W[r-2]; second pair: W[r-16], W[r-7]
    always_comb begin
        if (state_reg == ST_RD_SIG) begin
            addr_a = slot + SLOT_W'(1);
            addr_b = slot + SLOT_W'(14);
        end else begin
            addr_a = slot;
            addr_b = slot + SLOT_W'(9);
        end
    end

    assign w_new = (round_reg < ROUND_W'(BLOCK_WORDS)) ? rd_a_reg
                                                       : rd_a_reg + rd_b_reg + sig_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = word_cnt_reg;
        wr_data = s_tdata;
        if (state_reg == ST_LOAD) begin
            wr_en = s_acc;
        end else if (state_reg == ST_WORD) begin
            wr_en   = 1'b1;
            wr_addr = slot;
            wr_data = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sched_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= sched_mem[addr_a];
        rd_b_reg <= sched_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        sig_reg <= small_sigma0(rd_a_reg) + small_sigma1(rd_b_reg);
        if (state_reg == ST_WORD) begin
            w_reg  <= w_new;
            hk_reg <= var_reg[7] + RC[round_reg];
        end
        if (state_reg == ST_T1) begin
            t1_reg <= hk_reg + big_sigma1(var_reg[4])
                      + choose(var_reg[4], var_reg[5], var_reg[6]) + w_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_cnt_reg <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            end_reg      <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                hash_reg[i] <= IV[i];
                var_reg[i]  <= '0;
            end
        end else begin
            if (s_acc) begin
                word_cnt_reg <= word_cnt_reg + SLOT_W'(1);
            end
            if (block_done) begin
                end_reg   <= s_tlast;
                round_reg <= '0;
                for (int i = 0; i < HASH_WORDS; i++) begin
                    var_reg[i] <= hash_reg[i];
                end
            end
            if (state_reg == ST_UPD) begin
                var_reg[0] <= t1_reg + big_sigma0(var_reg[0])
                              + majority(var_reg[0], var_reg[1], var_reg[2]);
                var_reg[1] <= var_reg[0];
                var_reg[2] <= var_reg[1];
                var_reg[3] <= var_reg[2];
                var_reg[4] <= var_reg[3] + t1_reg;
                var_reg[5] <= var_reg[4];
                var_reg[6] <= var_reg[5];
                var_reg[7] <= var_reg[6];
                round_reg  <= round_reg + ROUND_W'(1);
            end
            if (state_reg == ST_ADD) begin
                out_idx_reg <= '0;
                for (int i = 0; i < HASH_WORDS; i++) begin
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
                end
            end
            if (m_acc) begin
                out_idx_reg <= out_idx_reg + HIDX_W'(1);
                if (out_idx_reg == HIDX_W'(HASH_WORDS - 1)) begin
                    for (int i = 0; i < HASH_WORDS; i++) begin
                        hash_reg[i] <= IV[i];
                    end
                end
            end
        end
    end

    assign m_tdata = hash_reg[out_idx_reg];
    assign m_tlast = (out_idx_reg == HIDX_W'(HASH_WORDS - 1));

endmodule
